>>> rtl/zambretti_forecast_classifier_assert.svh
// Assertion macros for the forecast classifier checker.
`ifndef ZAMBRETTI_FORECAST_CLASSIFIER_ASSERT_SVH
`define ZAMBRETTI_FORECAST_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define ZFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zfc checker: same-cycle implication failed");

// Next-cycle implication, disabled while rst is high.
`define ZFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zfc checker: next-cycle implication failed");

`endif

>>> rtl/zfc_pkg.sv
`default_nettype none

package zfc_pkg;

   // Trend codes
   localparam logic [1:0] TREND_FALLING = 2'd0;
   localparam logic [1:0] TREND_STEADY  = 2'd1;
   localparam logic [1:0] TREND_RISING  = 2'd2;
   localparam logic [1:0] TREND_UNKNOWN = 2'd3;

   // Divisors scaled by 16 and by the pressure fraction (16 * 8.1 * 10 etc.)
   localparam int FallDen   = 1296;
   localparam int SteadyDen = 6016;
   localparam int RiseDen   = 2064;

   // Lowest Z of each letter table
   localparam int FallLo   = 1;
   localparam int SteadyLo = 10;
   localparam int RiseLo   = 20;

   localparam logic [4:0] NO_LETTER = 5'd0;

   typedef struct packed {
      logic [14:0] pressure_x16;
      logic [1:0]  trend;
      logic [3:0]  month;
   } req_type;

   typedef struct packed {
      logic [4:0] letter_code;
      logic [3:0] image_number;
   } rsp_type;

   // After the arithmetic stage: x = 2 * num + den
   typedef struct packed {
      logic signed [22:0] x;
      logic [1:0]         trend;
      logic               winter;
   } s1_type;

   // After the compare stage: table index and match flag
   typedef struct packed {
      logic [3:0] idx;
      logic       hit;
      logic [1:0] trend;
      logic       winter;
   } s2_type;

   localparam logic [4:0] FALL_TAB [16] = '{
      5'd1, 5'd2, 5'd4, 5'd8, 5'd15, 5'd18, 5'd21, 5'd22,
      5'd24, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
   };
   localparam logic [4:0] STEADY_TAB [16] = '{
      5'd1, 5'd2, 5'd5, 5'd11, 5'd14, 5'd16, 5'd19, 5'd23,
      5'd24, 5'd26, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
   };
   localparam logic [4:0] RISE_TAB [16] = '{
      5'd1, 5'd2, 5'd3, 5'd6, 5'd7, 5'd9, 5'd10, 5'd12,
      5'd13, 5'd17, 5'd20, 5'd25, 5'd26, 5'd0, 5'd0, 5'd0
   };

   localparam logic [3:0] IMG_SUMMER [32] = '{
      4'd9, 4'd1, 4'd1, 4'd4, 4'd2, 4'd2, 4'd4, 4'd2,
      4'd2, 4'd2, 4'd8, 4'd2, 4'd8, 4'd8, 4'd2, 4'd2,
      4'd8, 4'd4, 4'd5, 4'd5, 4'd8, 4'd5, 4'd5, 4'd5,
      4'd5, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9
   };
   localparam logic [3:0] IMG_WINTER [32] = '{
      4'd9, 4'd1, 4'd1, 4'd4, 4'd3, 4'd3, 4'd4, 4'd3,
      4'd3, 4'd3, 4'd8, 4'd3, 4'd8, 4'd8, 4'd3, 4'd3,
      4'd8, 4'd4, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6,
      4'd6, 4'd7, 4'd7, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9
   };

   // Constant part of 2 * num + den for each trend and season
   function automatic logic [20:0] base_of(input logic [1:0] trend, input logic winter);
      int b;
      b = 0;
      case (trend)
         TREND_FALLING: b = (2 * (130 + (winter ? 1 : 2)) + 1) * FallDen;
         TREND_STEADY:  b = (2 * 147 + 1) * SteadyDen;
         TREND_RISING:  b = (2 * (179 - (winter ? 1 : 2)) + 1) * RiseDen;
         default:       b = 0;
      endcase
      return 21'(b);
   endfunction

   // Pressure coefficient of 2 * num
   function automatic logic [6:0] coef_of(input logic [1:0] trend);
      logic [6:0] c;
      case (trend)
         TREND_FALLING: c = 7'd20;
         TREND_STEADY:  c = 7'd100;
         TREND_RISING:  c = 7'd40;
         default:       c = 7'd0;
      endcase
      return c;
   endfunction

   // Number of letter table entries for a trend
   function automatic logic [3:0] span_of(input logic [1:0] trend);
      logic [3:0] s;
      case (trend)
         TREND_FALLING: s = 4'd9;
         TREND_STEADY:  s = 4'd10;
         TREND_RISING:  s = 4'd13;
         default:       s = 4'd0;
      endcase
      return s;
   endfunction

   // Threshold on x for rounded Z >= lo + k
   function automatic logic signed [22:0] thr_of(input logic [1:0] trend, input logic [3:0] k);
      int den;
      int lo;
      den = 0;
      lo  = 0;
      case (trend)
         TREND_FALLING: begin
            den = FallDen;
            lo  = FallLo;
         end
         TREND_STEADY: begin
            den = SteadyDen;
            lo  = SteadyLo;
         end
         TREND_RISING: begin
            den = RiseDen;
            lo  = RiseLo;
         end
         default: begin
            den = 0;
            lo  = 0;
         end
      endcase
      return 23'(2 * den * (lo + int'(k)));
   endfunction

   // Letter code from trend and table index
   function automatic logic [4:0] letter_of(input logic [1:0] trend, input logic [3:0] idx);
      logic [4:0] c;
      case (trend)
         TREND_FALLING: c = FALL_TAB[idx];
         TREND_STEADY:  c = STEADY_TAB[idx];
         TREND_RISING:  c = RISE_TAB[idx];
         default:       c = NO_LETTER;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/zfc_arith.sv
`default_nettype none

module zfc_arith (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire zfc_pkg::req_type in_data,
   input  wire logic             down_en,
   output logic                  up_en,
   output logic                  out_valid,
   output zfc_pkg::s1_type       out_data
);
   import zfc_pkg::*;

   logic    valid_ff;
   s1_type  data_ff;
   s1_type  data_in;
   logic [20:0] base_w;
   logic [22:0] prod_w;
   logic        winter_w;

   // Load when empty or when the next stage takes the current request
   assign up_en = ~valid_ff | down_en;

   // Form x = 2 * num + den for the selected trend
   always_comb begin
      winter_w = (in_data.month < 4'd4) || (in_data.month > 4'd9);
      base_w   = base_of(in_data.trend, winter_w);
      prod_w   = 23'(coef_of(in_data.trend)) * 23'(in_data.pressure_x16);
      data_in.x      = signed'(23'(base_w) - prod_w);
      data_in.trend  = in_data.trend;
      data_in.winter = winter_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/zfc_grade.sv
`default_nettype none

module zfc_grade (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire zfc_pkg::s1_type in_data,
   input  wire logic            down_en,
   output logic                 up_en,
   output logic                 out_valid,
   output zfc_pkg::s2_type      out_data
);
   import zfc_pkg::*;

   logic       valid_ff;
   s2_type     data_ff;
   s2_type     data_in;
   logic [3:0] span_w;

   // Load when empty or when the next stage takes the current request
   assign up_en = ~valid_ff | down_en;

   // Round Z by comparing x against the table thresholds
   always_comb begin
      span_w      = span_of(in_data.trend);
      data_in.idx = 4'd0;
      for (int j = 1; j <= 12; j++) begin
         if ((4'(j) < span_w) && (in_data.x >= thr_of(in_data.trend, 4'(j)))) begin
            data_in.idx = data_in.idx + 4'd1;
         end
      end
      data_in.hit    = (in_data.trend != TREND_UNKNOWN) &&
                       (in_data.x >= thr_of(in_data.trend, 4'd0)) &&
                       (in_data.x <  thr_of(in_data.trend, span_w));
      data_in.trend  = in_data.trend;
      data_in.winter = in_data.winter;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/zfc_lookup.sv
`default_nettype none

module zfc_lookup (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire zfc_pkg::s2_type in_data,
   input  wire logic            down_en,
   output logic                 up_en,
   output logic                 out_valid,
   output zfc_pkg::rsp_type     out_data
);
   import zfc_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;

   // Load when empty or when the consumer takes the current request
   assign up_en = ~valid_ff | down_en;

   // Map index to letter, then letter to picture
   always_comb begin
      data_in.letter_code  = in_data.hit ? letter_of(in_data.trend, in_data.idx) : NO_LETTER;
      data_in.image_number = in_data.winter ? IMG_WINTER[data_in.letter_code]
                                            : IMG_SUMMER[data_in.letter_code];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/zambretti_forecast_classifier.sv
`default_nettype none

// Zambretti forecast classifier: each request carries a pressure sample (hPa
// with four fraction bits), a trend and a month, and yields one response with
// the forecast letter code (0 when no letter applies) and the picture number.
// A request is taken every cycle when nothing stalls, and its response passes
// through three register stages in order: the pressure arithmetic,
// the rounding comparisons against the letter table thresholds, and the
// letter and picture table lookup. The response register holds a stalled
// response while the earlier stages keep filling, so req_stall rises only
// once all three stages hold requests.
module zambretti_forecast_classifier (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire zfc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output zfc_pkg::rsp_type      rsp_data
);
   import zfc_pkg::*;

   logic   arith_en;
   logic   grade_en;
   logic   lookup_en;
   logic   s1_valid;
   logic   s2_valid;
   s1_type s1_data;
   s2_type s2_data;

   // Stall the requester when the first stage cannot load
   assign req_stall = ~arith_en;

   zfc_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .down_en   (grade_en),
      .up_en     (arith_en),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   zfc_grade u_grade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .down_en   (lookup_en),
      .up_en     (grade_en),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   zfc_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .down_en   (~rsp_stall),
      .up_en     (lookup_en),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/zfc_checker.sv
`default_nettype none

`include "zambretti_forecast_classifier_assert.svh"

module zfc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire zfc_pkg::rsp_type rsp_data
);
   import zfc_pkg::*;

   logic rsp_held_w;
   logic no_letter_w;
   logic pic_ok_w;

   // Derive the response conditions the checks look at
   assign rsp_held_w  = rsp_valid && rsp_stall;
   assign no_letter_w = rsp_valid && (rsp_data.letter_code == NO_LETTER);
   assign pic_ok_w    = (rsp_data.image_number >= 4'd1) && (rsp_data.image_number <= 4'd8);

   // Reset empties the response register
   `ZFC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // An empty response register never backs up the request side
   `ZFC_ASSERT_IMPLY(a_empty_no_stall, clock, reset, !rsp_valid, !req_stall)
   // A stalled response stays and holds its value
   `ZFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held_w, rsp_valid && $stable(rsp_data))
   // No letter goes with picture nine, a letter with pictures one to eight
   `ZFC_ASSERT_IMPLY(a_no_letter_pic, clock, reset, no_letter_w, rsp_data.image_number == 4'd9)
   `ZFC_ASSERT_IMPLY(a_letter_pic, clock, reset, rsp_valid && !no_letter_w, pic_ok_w && (rsp_data.letter_code <= 5'd26))

endmodule

bind zambretti_forecast_classifier zfc_checker u_zfc_checker (.*);

`default_nettype wire
